// File: hdl/acls_pkg.sv
// ============================================================================
// acls_pkg: shared types and constants for the channel level meter
// Field widths, dB limits, log conversion constant and sequencer states.
// ============================================================================
package acls_pkg;

    localparam int MAX_SAMPLES_DEF  = 65536;
    localparam int MAX_CHANNELS_DEF = 256;

    localparam int CNT_W = 17;
    localparam int CH_W  = 8;

    localparam logic signed [18:0] DB_FLOOR = -19'sd51200;
    localparam logic signed [18:0] DB_CEIL  = 19'sd197376;
    localparam logic [26:0] DB_PER_LOG2_Q24 = 27'd101008905;
    localparam logic [22:0] Q23_MAX = 23'h7FFFFF;

    // Snapshot of one finished channel, handed from front to back.
    typedef struct packed {
        logic [CH_W-1:0]   chan;
        logic [30:0]       peak;
        logic [63:0]       energy;
        logic [CNT_W-1:0]  finite;
        logic [CNT_W-1:0]  nan_cnt;
        logic [CNT_W-1:0]  inf_cnt;
        logic [CNT_W-1:0]  sub_cnt;
        logic [CNT_W-1:0]  first_nz;
    } chan_stats_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_PLOG_INIT,
        ST_PLOG,
        ST_PDB,
        ST_RLOG_INIT,
        ST_RLOG,
        ST_RDB,
        ST_OUT
    } back_state_t;

endpackage

// File: hdl/acls_front.sv
// ============================================================================
// acls_front: per-sample classification and accumulation
// Classifies each float sample, updates tallies, peak and energy, and pushes
// a channel snapshot into the queue on the last sample.
// ============================================================================
module acls_front #(
    parameter int MAX_SAMPLES  = acls_pkg::MAX_SAMPLES_DEF,
    parameter int MAX_CHANNELS = acls_pkg::MAX_CHANNELS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [31:0]           sample_bits,
    input  logic                  last_in_channel,
    output logic                  push,
    output acls_pkg::chan_stats_t push_data,
    input  logic                  full
);
    import acls_pkg::*;

    localparam logic [CNT_W-1:0] MAXS = CNT_W'(MAX_SAMPLES);

    logic [CNT_W-1:0] pos_reg, nan_reg, inf_reg, sub_reg, fin_reg, fnz_reg;
    logic [CNT_W-1:0] pos_next, nan_next, inf_next, sub_next, fin_next, fnz_next;
    logic [30:0]      peak_reg, peak_next;
    logic [63:0]      energy_reg, energy_next;
    logic [CH_W-1:0]  chan_reg, chan_next;

    // one-stage square pipe
    logic             sq_vld_reg;
    logic [45:0]      sq_reg;

    logic [30:0] mag;
    logic [7:0]  e;
    logic [22:0] f;
    logic [22:0] m;
    logic [7:0]  sh;
    logic        fin, accept;
    logic [64:0] esum;
    logic [63:0] energy_eff;

    assign in_stall = full;
    assign accept   = in_valid && !full;
    assign mag = sample_bits[30:0];
    assign e   = mag[30:23];
    assign f   = mag[22:0];
    assign fin = (e != 8'hFF);
    assign sh  = 8'd127 - e;

    always_comb
    begin
        m = '0;
        if (e >= 8'd127)
            m = Q23_MAX;
        else if (e != 8'd0)
            m = (sh < 8'd24) ? 23'({1'b1, f} >> sh[4:0]) : 23'd0;
    end

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c < MAXS) ? c + 1'b1 : MAXS;
    endfunction

    // energy including the square still in flight
    assign esum       = {1'b0, energy_reg} + {19'd0, sq_reg};
    assign energy_eff = sq_vld_reg ? (esum[64] ? '1 : esum[63:0]) : energy_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        nan_next    = nan_reg;
        inf_next    = inf_reg;
        sub_next    = sub_reg;
        fin_next    = fin_reg;
        fnz_next    = fnz_reg;
        peak_next   = peak_reg;
        energy_next = energy_eff;
        chan_next   = chan_reg;
        if (accept)
        begin
            pos_next = sat_inc(pos_reg);
            if (!fin)
            begin
                if (f != '0)
                    nan_next = sat_inc(nan_reg);
                else
                    inf_next = sat_inc(inf_reg);
            end
            else
            begin
                if (e == 8'd0 && f != '0)
                    sub_next = sat_inc(sub_reg);
                if (mag != '0 && fnz_reg[CNT_W-1] && fnz_reg == '1)
                    fnz_next = (pos_reg < MAXS) ? pos_reg : MAXS - 1'b1;
                if (mag > peak_reg)
                    peak_next = mag;
                fin_next = sat_inc(fin_reg);
            end
            if (last_in_channel)
            begin
                pos_next    = '0;
                nan_next    = '0;
                inf_next    = '0;
                sub_next    = '0;
                fin_next    = '0;
                fnz_next    = '1;
                peak_next   = '0;
                energy_next = '0;
                chan_next   = (chan_reg == CH_W'(MAX_CHANNELS - 1)) ? '0 : chan_reg + 1'b1;
            end
        end
    end

    // final square of the last sample is added in the snapshot
    logic [45:0] sq_now;
    logic [64:0] fsum;
    assign sq_now = fin ? 46'(m) * 46'(m) : '0;
    assign fsum   = {1'b0, energy_eff} + {19'd0, sq_now};

    assign push = accept && last_in_channel;
    always_comb
    begin
        push_data.chan     = chan_reg;
        push_data.peak     = (fin && mag > peak_reg) ? mag : peak_reg;
        push_data.energy   = fsum[64] ? '1 : fsum[63:0];
        push_data.finite   = fin ? sat_inc(fin_reg) : fin_reg;
        push_data.nan_cnt  = (!fin && f != '0) ? sat_inc(nan_reg) : nan_reg;
        push_data.inf_cnt  = (!fin && f == '0) ? sat_inc(inf_reg) : inf_reg;
        push_data.sub_cnt  = (fin && e == 8'd0 && f != '0) ? sat_inc(sub_reg) : sub_reg;
        push_data.first_nz = (fin && mag != '0 && fnz_reg == '1)
                           ? ((pos_reg < MAXS) ? pos_reg : MAXS - 1'b1) : fnz_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            nan_reg    <= '0;
            inf_reg    <= '0;
            sub_reg    <= '0;
            fin_reg    <= '0;
            fnz_reg    <= '1;
            peak_reg   <= '0;
            energy_reg <= '0;
            chan_reg   <= '0;
            sq_vld_reg <= 1'b0;
            sq_reg     <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            nan_reg    <= nan_next;
            inf_reg    <= inf_next;
            sub_reg    <= sub_next;
            fin_reg    <= fin_next;
            fnz_reg    <= fnz_next;
            peak_reg   <= peak_next;
            energy_reg <= energy_next;
            chan_reg   <= chan_next;
            sq_vld_reg <= accept && fin && !last_in_channel;
            sq_reg     <= sq_now;
        end
    end

endmodule

// File: hdl/acls_queue.sv
// ============================================================================
// acls_queue: two-entry snapshot queue between front and back
// Lets the front keep accepting samples while the back works on a channel.
// ============================================================================
module acls_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  acls_pkg::chan_stats_t push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output acls_pkg::chan_stats_t pop_data
);
    import acls_pkg::*;

    chan_stats_t mem_reg [2];
    logic        wr_reg, rd_reg;
    logic [1:0]  cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// File: hdl/acls_back.sv
// ============================================================================
// acls_back: per-channel result sequencer
// Radix-2 divider, digit-by-digit square root, squaring log2 and dB scaling,
// shared over peak and RMS, with an output register.
// ============================================================================
module acls_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  acls_pkg::chan_stats_t q_data,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            channel_number,
    output logic [30:0]           peak_magnitude_bits,
    output logic [22:0]           rms_level,
    output logic signed [18:0]    peak_decibels,
    output logic signed [16:0]    rms_decibels,
    output logic [16:0]           nan_total,
    output logic [16:0]           infinity_total,
    output logic [16:0]           subnormal_total,
    output logic signed [16:0]    first_nonzero_index
);
    import acls_pkg::*;

    back_state_t state_reg, state_next;
    chan_stats_t d_reg;
    logic [6:0]  step_reg, step_next;

    // divider
    logic [63:0] quo_reg;
    logic [16:0] rem_reg;
    logic [17:0] rtrial;
    // sqrt
    logic [63:0] sn_reg;
    logic [31:0] sr_reg;
    logic [63:0] scmp;
    // log
    logic [32:0] y_reg;
    logic [23:0] frac_reg;
    logic signed [9:0] ip_reg;
    logic [65:0] ysq;
    logic [34:0] ysh;
    logic [4:0]  lead;
    logic [31:0] lv;
    logic signed [9:0] loff;
    logic signed [34:0] l_reg;
    logic [33:0] lmag;
    logic [60:0] prod_reg;
    logic        lneg_reg;
    logic signed [18:0] dbv;
    logic [22:0] rms_reg;

    logic out_vld_reg;
    logic out_take;
    assign out_take = out_vld_reg && !out_stall;

    // log source and leading one
    always_comb
    begin
        lv   = '0;
        loff = '0;
        if (state_reg == ST_PLOG_INIT)
        begin
            if (d_reg.peak[30:23] == 8'd0)
            begin
                lv   = {9'd0, d_reg.peak[22:0]};
                loff = -10'sd149;
            end
            else
            begin
                lv   = {8'd0, 1'b1, d_reg.peak[22:0]};
                loff = $signed({2'b00, d_reg.peak[30:23]}) - 10'sd150;
            end
        end
        else
        begin
            lv   = {9'd0, rms_reg};
            loff = -10'sd23;
        end
        lead = '0;
        for (int i = 0; i < 32; i++)
            if (lv[i])
                lead = 5'(i);
    end

    assign rtrial = {rem_reg, quo_reg[63]};
    // (r + 2^s)^2 - r^2
    assign scmp   = (64'(sr_reg) << (step_reg + 7'd1)) + (64'd1 << {step_reg[4:0], 1'b0});
    assign ysq    = {33'd0, y_reg} * {33'd0, y_reg};
    assign ysh    = ysq[65:31];
    assign lmag   = l_reg[34] ? 34'(-l_reg) : 34'(l_reg);

    always_comb
    begin
        begin : round_db
            logic [61:0] r;
            logic signed [22:0] d;
            r = {1'b0, prod_reg} + (62'd1 << 39);
            d = lneg_reg ? -$signed({1'b0, r[61:40]}) : $signed({1'b0, r[61:40]});
            if (d < 23'(DB_FLOOR))
                dbv = DB_FLOOR;
            else if (d > 23'(DB_CEIL))
                dbv = DB_CEIL;
            else
                dbv = 19'(d);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
                if (q_valid)
                begin
                    state_next = ST_DIV;
                    step_next  = 7'd63;
                end
            ST_DIV:
                if (d_reg.finite == '0 || step_reg == '0)
                begin
                    state_next = ST_SQRT;
                    step_next  = 7'd31;
                end
                else
                    step_next = step_reg - 1'b1;
            ST_SQRT:
                if (step_reg == '0)
                    state_next = ST_PLOG_INIT;
                else
                    step_next = step_reg - 1'b1;
            ST_PLOG_INIT:
            begin
                step_next  = 7'd23;
                state_next = (d_reg.peak == '0) ? ST_RLOG_INIT : ST_PLOG;
            end
            ST_PLOG:
                if (step_reg == '0)
                    state_next = ST_PDB;
                else
                    step_next = step_reg - 1'b1;
            ST_PDB:
                state_next = ST_RLOG_INIT;
            ST_RLOG_INIT:
            begin
                step_next  = 7'd23;
                state_next = (rms_reg == '0) ? ST_OUT : ST_RLOG;
            end
            ST_RLOG:
                if (step_reg == '0)
                    state_next = ST_RDB;
                else
                    step_next = step_reg - 1'b1;
            ST_RDB:
                state_next = ST_OUT;
            ST_OUT:
                if (!out_vld_reg || out_take)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (state_reg == ST_OUT && (!out_vld_reg || out_take))
                out_vld_reg <= 1'b1;
            else if (out_take)
                out_vld_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (q_valid)
                begin
                    d_reg   <= q_data;
                    quo_reg <= q_data.energy;
                    rem_reg <= '0;
                    rms_reg <= '0;
                    l_reg   <= '0;
                    lneg_reg <= 1'b0;
                    prod_reg <= '0;
                end
            ST_DIV:
                if (d_reg.finite == '0)
                    quo_reg <= '0;
                else if (rtrial >= {1'b0, d_reg.finite})
                begin
                    rem_reg <= 17'(rtrial - {1'b0, d_reg.finite});
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rtrial[16:0];
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
            default:
            begin
            end
        endcase
        if (state_reg == ST_DIV && (d_reg.finite == '0 || step_reg == '0))
        begin
            sn_reg <= (d_reg.finite == '0) ? '0
                    : (rtrial >= {1'b0, d_reg.finite}) ? {quo_reg[62:0], 1'b1}
                    : {quo_reg[62:0], 1'b0};
            sr_reg <= '0;
        end
        if (state_reg == ST_SQRT)
        begin
            // restoring root, one result bit per step
            if (sn_reg >= scmp)
            begin
                sn_reg <= sn_reg - scmp;
                sr_reg <= sr_reg | (32'd1 << step_reg[4:0]);
            end
            if (step_reg == '0)
                rms_reg <= '0;
        end
        if (state_reg == ST_PLOG_INIT)
        begin
            rms_reg  <= (sr_reg > 32'(Q23_MAX)) ? Q23_MAX : sr_reg[22:0];
            y_reg    <= {1'b0, lv << (5'd31 - lead)};
            ip_reg   <= 10'($signed({5'd0, lead})) + loff;
            frac_reg <= '0;
        end
        if (state_reg == ST_RLOG_INIT)
        begin
            y_reg    <= {1'b0, lv << (5'd31 - lead)};
            ip_reg   <= 10'($signed({5'd0, lead})) + loff;
            frac_reg <= '0;
        end
        if (state_reg == ST_PLOG || state_reg == ST_RLOG)
        begin
            if (ysh[32])
            begin
                y_reg    <= ysh[33:1];
                frac_reg <= {frac_reg[22:0], 1'b1};
            end
            else
            begin
                y_reg    <= ysh[32:0];
                frac_reg <= {frac_reg[22:0], 1'b0};
            end
            if (step_reg == '0)
            begin
                l_reg <= 35'(ip_reg) * 35'sd16777216
                       + $signed({11'd0, frac_reg[22:0], ysh[32]});
            end
        end
        if (state_reg == ST_PDB || state_reg == ST_RDB)
        begin
            lneg_reg <= l_reg[34];
            prod_reg <= 61'(lmag) * 61'(DB_PER_LOG2_Q24);
        end
    end

    // dB rounding is combinational on the registered product; latched at next state
    logic signed [18:0] pdb_hold_reg, rdb_hold_reg;
    logic               pdb_pend_reg, rdb_pend_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pdb_pend_reg <= 1'b0;
            rdb_pend_reg <= 1'b0;
        end
        else
        begin
            pdb_pend_reg <= (state_reg == ST_PDB);
            rdb_pend_reg <= (state_reg == ST_RDB);
        end
    end
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            pdb_hold_reg <= DB_FLOOR;
            rdb_hold_reg <= DB_FLOOR;
        end
        if (pdb_pend_reg)
            pdb_hold_reg <= dbv;
        if (rdb_pend_reg)
            rdb_hold_reg <= dbv;
    end

    // output register; rms dB is still in rounding on the first ST_OUT cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && (!out_vld_reg || out_take))
        begin
            channel_number      <= d_reg.chan;
            peak_magnitude_bits <= d_reg.peak;
            rms_level           <= rms_reg;
            peak_decibels       <= pdb_hold_reg;
            rms_decibels        <= rdb_pend_reg ? dbv[16:0] : rdb_hold_reg[16:0];
            nan_total           <= d_reg.nan_cnt;
            infinity_total      <= d_reg.inf_cnt;
            subnormal_total     <= d_reg.sub_cnt;
            first_nonzero_index <= d_reg.first_nz;
        end
    end

    assign out_valid = out_vld_reg;

endmodule

// File: hdl/audio_channel_level_stats.sv
// ============================================================================
// audio_channel_level_stats: per-channel peak and RMS level meter
// ============================================================================
// Samples are taken one per cycle with no bubbles; the front stalls only when
// the two-entry channel queue is full. Each finished channel then passes through
// the back sequencer (a pickup state, 64-step divider, 32-step root, up to two
// 24-step squaring logs with their setup and dB scaling states, and an output
// state), so short channels fill the queue and throttle input.
module audio_channel_level_stats #(
    parameter int MAX_SAMPLES  = acls_pkg::MAX_SAMPLES_DEF,
    parameter int MAX_CHANNELS = acls_pkg::MAX_CHANNELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [31:0]         sample_bits,
    input  logic                last_in_channel,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          channel_number,
    output logic [30:0]         peak_magnitude_bits,
    output logic [22:0]         rms_level,
    output logic signed [18:0]  peak_decibels,
    output logic signed [16:0]  rms_decibels,
    output logic [16:0]         nan_total,
    output logic [16:0]         infinity_total,
    output logic [16:0]         subnormal_total,
    output logic signed [16:0]  first_nonzero_index
);
    import acls_pkg::*;

    logic        push, full, pop, not_empty;
    chan_stats_t push_data, pop_data;

    acls_front #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sample_bits     (sample_bits),
        .last_in_channel (last_in_channel),
        .push            (push),
        .push_data       (push_data),
        .full            (full)
    );

    acls_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_data  (pop_data)
    );

    acls_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .q_valid             (not_empty),
        .q_data              (pop_data),
        .q_pop               (pop),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .channel_number      (channel_number),
        .peak_magnitude_bits (peak_magnitude_bits),
        .rms_level           (rms_level),
        .peak_decibels       (peak_decibels),
        .rms_decibels        (rms_decibels),
        .nan_total           (nan_total),
        .infinity_total      (infinity_total),
        .subnormal_total     (subnormal_total),
        .first_nonzero_index (first_nonzero_index)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full)) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty)) else $error("pop from empty queue");
    a_rms_db_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rms_decibels <= 17'sd0) else $error("rms dB above zero");

endmodule

// File: bench/audio_channel_level_stats_test.sv
`timescale 1ns / 1ps
// ============================================================================
// audio_channel_level_stats_test: self-checking bench for the level meter
// Streams float samples grouped into channels, predicts each channel's
// peak, RMS, dB levels and counts, and compares every result transfer.
// ============================================================================
module audio_channel_level_stats_test;
    import acls_pkg::*;

    localparam int LIMIT = 20000;

    typedef struct {
        logic [31:0] bits;
        logic        last;
    } sample_t;

    typedef struct {
        logic [7:0]         chan;
        logic [30:0]        peak;
        logic [22:0]        rms;
        logic signed [18:0] pdb;
        logic signed [16:0] rdb;
        logic [16:0]        nans;
        logic [16:0]        infs;
        logic [16:0]        subs;
        logic signed [16:0] first_nz;
    } level_t;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic [31:0]        sample_bits = 0;
    logic               last_in_channel = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic [7:0]         channel_number;
    logic [30:0]        peak_magnitude_bits;
    logic [22:0]        rms_level;
    logic signed [18:0] peak_decibels;
    logic signed [16:0] rms_decibels;
    logic [16:0]        nan_total;
    logic [16:0]        infinity_total;
    logic [16:0]        subnormal_total;
    logic signed [16:0] first_nonzero_index;

    audio_channel_level_stats dut (.*);

    always #4 clk = ~clk;

    sample_t pending_samples[$];
    level_t  expected_levels[$];
    int      errors = 0;
    int      channels_seen = 0;
    int      samples_sent = 0;
    int      idle_count = 0;
    bit      calm = 0;
    bit      all_queued = 0;
    int      hold_off = 0;

    // channel accumulator
    int unsigned     pos, nan_n, inf_n, sub_n, fin_n;
    int              first_seen;
    logic [30:0]     peak_bits;
    longint unsigned energy;
    logic [7:0]      chan_idx;

    function automatic int unsigned bump(int unsigned c);
        return c < MAX_SAMPLES_DEF ? c + 1 : MAX_SAMPLES_DEF;
    endfunction

    function automatic longint log2_fixed(longint unsigned v, int offset);
        int              k;
        longint unsigned y;
        longint          frac;
        k = 63;
        while (!v[k]) k--;
        y = v << (31 - k);
        frac = 0;
        for (int i = 0; i < 24; i++) begin
            y = (y * y) >> 31;
            frac = frac << 1;
            if (y >= 64'h1_0000_0000) begin
                frac = frac | 1;
                y = y >> 1;
            end
        end
        return longint'(k + offset) * 16777216 + frac;
    endfunction

    function automatic int to_db(longint l);
        longint unsigned m;
        longint          d;
        m = l < 0 ? -l : l;
        m = (m * 64'd101008905 + (64'd1 << 39)) >> 40;
        d = l < 0 ? -longint'(m) : longint'(m);
        if (d < -51200) d = -51200;
        if (d > 197376) d = 197376;
        return int'(d);
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic clear_channel();
        pos = 0; nan_n = 0; inf_n = 0; sub_n = 0; fin_n = 0;
        first_seen = -1; peak_bits = 0; energy = 0;
    endtask

    task automatic predict_level(sample_t s);
        logic [30:0]     mag;
        logic [7:0]      e;
        logic [22:0]     f;
        longint unsigned m, r;
        level_t          x;
        mag = s.bits[30:0];
        e = mag[30:23];
        f = mag[22:0];
        if (e == 255) begin
            if (f != 0) nan_n = bump(nan_n);
            else inf_n = bump(inf_n);
        end
        else begin
            m = 0;
            if (e == 0 && f != 0) sub_n = bump(sub_n);
            if (mag != 0 && first_seen < 0)
                first_seen = pos < MAX_SAMPLES_DEF ? pos : MAX_SAMPLES_DEF - 1;
            if (mag > peak_bits) peak_bits = mag;
            if (e >= 127) m = Q23_MAX;
            else if (e != 0 && 127 - e < 32) m = {1'b1, f} >> (127 - e);
            m = m * m;
            energy = (energy > 64'hFFFF_FFFF_FFFF_FFFF - m) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                            : energy + m;
            fin_n = bump(fin_n);
        end
        pos = bump(pos);
        if (!s.last) return;
        r = 0;
        if (fin_n != 0) begin
            r = root64(energy / fin_n);
            if (r > Q23_MAX) r = Q23_MAX;
        end
        x.chan = chan_idx;
        x.peak = peak_bits;
        x.rms = r;
        x.pdb = -51200;
        x.rdb = -51200;
        if (peak_bits != 0)
            x.pdb = to_db(peak_bits[30:23] == 0
                ? log2_fixed(peak_bits[22:0], -149)
                : log2_fixed({1'b1, peak_bits[22:0]}, int'(peak_bits[30:23]) - 150));
        if (r != 0) x.rdb = to_db(log2_fixed(r, -23));
        x.nans = nan_n;
        x.infs = inf_n;
        x.subs = sub_n;
        x.first_nz = first_seen;
        expected_levels.insert(expected_levels.size(), x);
        clear_channel();
        chan_idx++;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch ch %0d %s: got %0d want %0d", channels_seen, what, got, want);
        errors++;
    endtask

    function automatic logic [31:0] random_sample();
        int unsigned k;
        logic [31:0] v;
        k = $urandom_range(0, 11);
        v = $urandom;
        case (k)
            0: v[30:23] = 8'hFF;
            1: v[30:0] = {8'hFF, 23'd0};
            2: v[30:23] = 0;
            3: v[30:0] = 0;
            4, 5, 6: v[30:23] = $urandom_range(100, 126);
            7: v[30:23] = $urandom_range(127, 254);
            default: ;
        endcase
        return v;
    endfunction

    task automatic add_sample(logic [31:0] b, logic l);
        sample_t s;
        s.bits = b;
        s.last = l;
        pending_samples.insert(pending_samples.size(), s);
    endtask

    // driver
    always @(posedge clk) begin
        if (in_valid && !in_stall) begin
            predict_level('{sample_bits, last_in_channel});
            samples_sent++;
        end
        if (!(in_valid && in_stall)) begin
            if (pending_samples.size() > 0 && (calm || $urandom_range(0, 5) != 0 || idle_count > 0)
                && idle_count == 0) begin
                sample_t s;
                s = pending_samples.pop_front();
                in_valid <= 1;
                sample_bits <= s.bits;
                last_in_channel <= s.last;
            end
            else begin
                in_valid <= 0;
                sample_bits <= $urandom;
                last_in_channel <= $urandom;
                if (idle_count > 0) idle_count--;
                else if (!calm && pending_samples.size() > 0) idle_count = $urandom_range(0, 10);
            end
        end
    end

    // monitor
    int stall_left = 0;
    always @(posedge clk) begin
        if (out_valid && !out_stall) begin
            if (expected_levels.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end
            else begin
                level_t x;
                x = expected_levels.pop_front();
                if (channel_number !== x.chan) report_mismatch("chan", channel_number, x.chan);
                if (peak_magnitude_bits !== x.peak)
                    report_mismatch("peak", peak_magnitude_bits, x.peak);
                if (rms_level !== x.rms) report_mismatch("rms", rms_level, x.rms);
                if (peak_decibels !== x.pdb) report_mismatch("peak dB", peak_decibels, x.pdb);
                if (rms_decibels !== x.rdb) report_mismatch("rms dB", rms_decibels, x.rdb);
                if (nan_total !== x.nans) report_mismatch("nan", nan_total, x.nans);
                if (infinity_total !== x.infs) report_mismatch("inf", infinity_total, x.infs);
                if (subnormal_total !== x.subs) report_mismatch("sub", subnormal_total, x.subs);
                if (first_nonzero_index !== x.first_nz)
                    report_mismatch("first", first_nonzero_index, x.first_nz);
            end
            channels_seen++;
        end
        if (hold_off > 0) begin
            hold_off--;
            out_stall <= 1;
        end
        else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1;
        end
        else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 10);
            out_stall <= 1;
        end
        else out_stall <= 0;
    end

    // watchdog
    int quiet = 0;
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off > 0) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int n, tail;
        clear_channel();
        chan_idx = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        // directed: extremes and special cases
        add_sample(32'h0000_0000, 0); add_sample(32'h8000_0000, 0);
        add_sample(32'h3F80_0000, 0); add_sample(32'hBF00_0000, 1);
        add_sample(32'h7FC0_0000, 0); add_sample(32'hFF80_0000, 0);
        add_sample(32'h7F80_0000, 1);
        add_sample(32'h0000_0001, 0); add_sample(32'h807F_FFFF, 1);
        add_sample(32'h7F7F_FFFF, 0); add_sample(32'hFFFF_FFFF, 1);
        add_sample(32'h8000_0000, 1);
        add_sample(32'h3400_0000, 0); add_sample(32'h3A00_0000, 1);
        add_sample(32'h0080_0000, 1);
        for (int c = 0; c < 80; c++) begin
            n = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
            for (int i = 0; i < n; i++) add_sample(random_sample(), i == n - 1);
            if (c == 60) begin
                wait (pending_samples.size() == 0);
                hold_off = 600;
            end
        end
        for (int i = 0; i < 40; i++) add_sample(random_sample(), $urandom_range(0, 3) == 0);
        add_sample(random_sample(), 1);
        calm = 1;
        for (int c = 0; c < 30; c++) add_sample(random_sample(), 1);
        wait (pending_samples.size() == 0);
        @(posedge clk);
        while (in_valid && in_stall) @(posedge clk);
        @(posedge clk);
        wait (expected_levels.size() == 0);
        tail = 0;
        while (tail < 300) begin
            @(posedge clk);
            tail++;
        end
        $display("sent %0d samples, checked %0d channel results", samples_sent, channels_seen);
        $display("covered NaN, infinity, subnormal and signed-zero samples, output hold-off");
        if (errors == 0 && expected_levels.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: audio_channel_level_stats.f
hdl/acls_pkg.sv
hdl/acls_front.sv
hdl/acls_queue.sv
hdl/acls_back.sv
hdl/audio_channel_level_stats.sv
bench/audio_channel_level_stats_test.sv
